### hdl/rcu_pkg.sv
// Shared types and constants for the rotor cipher unit.
// Used by every module of the block and by its checker; depends on nothing.
package rcu_pkg;

  // Alphabet: 128 symbols of 7 bits, arithmetic wraps naturally.
  localparam int ALPHABET_SIZE = 128;
  localparam int SYM_W         = $clog2(ALPHABET_SIZE);
  localparam int OP_W          = 3;

  // Stream widths: fields packed from bit 0, padded to whole bytes.
  localparam int IN_FIELD_W = OP_W + 2 * SYM_W;
  localparam int IN_W       = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_W      = SYM_W + 1;

  // Result queue depth; also bounds results in flight.
  localparam int OUT_DEPTH = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTOR1_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTOR2_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTOR3_START = 2'd2;

  // Item operations.
  typedef enum logic [OP_W-1:0] {
    OP_CIPHER = 3'd0,
    OP_PLUG   = 3'd1,
    OP_ROTOR1 = 3'd2,
    OP_ROTOR2 = 3'd3,
    OP_ROTOR3 = 3'd4,
    OP_REFL   = 3'd5,
    OP_BEGIN  = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef logic [SYM_W-1:0] sym_t;

  // One item as it moves down the lookup pipeline.
  typedef struct packed {
    logic vld;
    op_t  op;
    sym_t sym;   // symbol being ciphered, or table position for loads
    sym_t val;   // table entry value for loads
    sym_t off1;
    sym_t off2;
    sym_t off3;
    logic miss;
  } pipe_t;

  // One result item, symbol in the low bits.
  typedef struct packed {
    logic lookup_miss;
    sym_t out_symbol;
  } res_t;

endpackage

### hdl/rcu_lut.sv
// 128-entry symbol table with one write port and one registered read port.
// Optional per-entry valid flags cleared at reset. Depends on rcu_pkg.
module rcu_lut #(
  parameter bit HAS_VLD = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  rcu_pkg::sym_t      wr_addr,
  input  rcu_pkg::sym_t      wr_data,
  input  rcu_pkg::sym_t      rd_addr,
  output rcu_pkg::sym_t      rd_data,
  output logic               rd_vld
);
  import rcu_pkg::*;

  sym_t mem [ALPHABET_SIZE];
  sym_t rd_data_r;

  // Table storage: write and registered read share one clocked block.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

  generate
    if (HAS_VLD) begin : g_vld
      logic [ALPHABET_SIZE-1:0] vld_r;
      logic                     rd_vld_r;

      // Valid flags start clear; an entry becomes valid once written.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r <= '0;
        end else if (wr_en) begin
          vld_r[wr_addr] <= 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        rd_vld_r <= vld_r[rd_addr];
      end

      assign rd_vld = rd_vld_r;
    end else begin : g_no_vld
      assign rd_vld = 1'b1;
    end
  endgenerate

endmodule

### hdl/rcu_front.sv
// Input side: accepts items, splits plug pairs into two table writes,
// steps the rotor offsets and holds the start registers. Depends on rcu_pkg.
module rcu_front #(
  parameter int DEPTH = rcu_pkg::OUT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rcu_pkg::IN_W-1:0]      in_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  rcu_pkg::sym_t                 cfg_data,
  input  logic                          out_done,
  output rcu_pkg::pipe_t                iss
);
  import rcu_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  op_t  in_op;
  sym_t in_idx;
  sym_t in_val;
  logic accept;
  logic take_cipher;

  sym_t start1_r, start2_r, start3_r;
  sym_t off1_r, off2_r, off3_r;
  sym_t off1_nxt, off2_nxt, off3_nxt;
  sym_t sc_r, sc_nxt;
  sym_t msc_r, msc_nxt;
  logic pend_r;
  sym_t pend_sym_r, pend_val_r;
  logic [CW-1:0] credit_r, credit_nxt;

  assign in_op  = op_t'(in_tdata[OP_W-1:0]);
  assign in_idx = in_tdata[OP_W+SYM_W-1:OP_W];
  assign in_val = in_tdata[OP_W+2*SYM_W-1:OP_W+SYM_W];

  // Stall for the second half of a plug pair, or when every queue slot
  // is already promised to a result.
  assign in_tready   = !pend_r && (credit_r < CW'(DEPTH));
  assign accept      = in_tvalid && in_tready;
  assign take_cipher = accept && (in_op == OP_CIPHER);
  assign cfg_ready   = 1'b1;

  // Start registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start1_r <= '0;
      start2_r <= '0;
      start3_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROTOR1_START: start1_r <= cfg_data;
        CFG_ROTOR2_START: start2_r <= cfg_data;
        CFG_ROTOR3_START: start3_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Rotor stepping: rotor one always moves, the middle counter decides
  // when rotors two and three move.
  always_comb begin
    off1_nxt = off1_r;
    off2_nxt = off2_r;
    off3_nxt = off3_r;
    sc_nxt   = sc_r;
    msc_nxt  = msc_r;
    if (accept) begin
      unique case (in_op)
        OP_BEGIN: begin
          off1_nxt = start1_r;
          off2_nxt = start2_r;
          off3_nxt = start3_r;
          sc_nxt   = SYM_W'(1);
          msc_nxt  = SYM_W'(1);
        end
        OP_CIPHER: begin
          sc_nxt = sc_r + SYM_W'(1);
          if (msc_r == '0) begin
            off3_nxt = off3_r + SYM_W'(1);
            off2_nxt = off2_r + SYM_W'(1);
            msc_nxt  = msc_r + SYM_W'(1);
          end else if (sc_nxt == '0) begin
            off2_nxt = off2_r + SYM_W'(1);
            msc_nxt  = msc_r + SYM_W'(1);
          end
          off1_nxt = off1_r + SYM_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off1_r <= '0;
      off2_r <= '0;
      off3_r <= '0;
      sc_r   <= SYM_W'(1);
      msc_r  <= SYM_W'(1);
    end else begin
      off1_r <= off1_nxt;
      off2_r <= off2_nxt;
      off3_r <= off3_nxt;
      sc_r   <= sc_nxt;
      msc_r  <= msc_nxt;
    end
  end

  // A plug pair becomes two writes: first end now, second end next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= accept && (in_op == OP_PLUG);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_sym_r <= in_val;
      pend_val_r <= in_idx;
    end
  end

  // Count results that are in flight or queued.
  always_comb begin
    credit_nxt = credit_r;
    if (take_cipher && !out_done) begin
      credit_nxt = credit_r + CW'(1);
    end else if (!take_cipher && out_done) begin
      credit_nxt = credit_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  // Item issued into the pipeline this cycle.
  always_comb begin
    iss      = '0;
    iss.off1 = off1_nxt;
    iss.off2 = off2_nxt;
    iss.off3 = off3_nxt;
    if (pend_r) begin
      iss.vld = 1'b1;
      iss.op  = OP_PLUG;
      iss.sym = pend_sym_r;
      iss.val = pend_val_r;
    end else begin
      iss.vld = accept;
      iss.op  = in_op;
      iss.sym = in_idx;
      iss.val = in_val;
    end
  end

endmodule

### hdl/rcu_ofifo.sv
// Result queue between the lookup pipeline and the output stream.
// Holds packed result items; depends on rcu_pkg.
module rcu_ofifo #(
  parameter int DEPTH = rcu_pkg::OUT_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  rcu_pkg::res_t             push_data,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [rcu_pkg::OUT_W-1:0] out_tdata
);
  import rcu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          pop;

  assign out_tvalid = (count_r != '0);
  assign out_tdata  = mem[rd_ptr_r];
  assign pop        = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

### hdl/rotor_cipher_128_unit.sv
// Top level of the three-rotor cipher: front end, nine-stage table pipeline
// and result queue. Depends on rcu_pkg, rcu_front, rcu_lut and rcu_ofifo.
//
// Use: items arrive on the in_ stream. Load items (plug pair, rotor entry,
// reflector entry) fill the tables, a begin item loads the rotor offsets from
// the cfg_ start registers, and each cipher item gives one result on the
// out_ stream. Start registers are written through the cfg_ channel, which is
// always ready; write them only while the block is idle.
// A result passes the nine table stages and the result queue before it is offered.
// Throughput: one item per cycle while the queue has room; a plug pair item
// stalls the next, as its two writes share each plug table's single write port.
// Each table lookup is one pipeline stage with a registered memory read, and
// loads write their table as they pass that same stage, so items see tables
// in exactly the order they arrived.
// Reset clears the plugboard, the inverse rotor valid flags, the offsets and
// the result queue; rotor and reflector tables hold nothing until loaded.
// When the receiver stalls, up to OUT_DEPTH results wait in the queue;
// in_tready drops once the results in flight and queued reach OUT_DEPTH.
module rotor_cipher_128_unit #(
  parameter int OUT_DEPTH = rcu_pkg::OUT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0: operation[2:0], index[9:3], value[16:10], zero pad.
  input  logic [rcu_pkg::IN_W-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // Fields from bit 0: out_symbol[6:0], lookup_miss[7].
  output logic [rcu_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcu_pkg::SYM_W-1:0]     cfg_data
);
  import rcu_pkg::*;

  pipe_t iss;
  pipe_t s0_r, s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r;
  pipe_t s6_nxt, s7_nxt, s8_nxt;

  sym_t pf_d, r1_d, r2_d, r3_d, rf_d, i3_d, i2_d, i1_d, pb_d;
  logic pf_v, r1_v, r2_v, r3_v, rf_v, i3_v, i2_v, i1_v, pb_v;

  sym_t c0, c5, c6, c7;
  logic out_done;
  logic push;
  res_t res;

  assign out_done = out_tvalid && out_tready;

  rcu_front #(
    .DEPTH(OUT_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_done  (out_done),
    .iss       (iss)
  );

  // Stage 0: plugboard on the way in.
  rcu_lut #(.HAS_VLD(1'b1)) u_plug_in (
    .clk(clk), .rst_n(rst_n),
    .wr_en(iss.vld && (iss.op == OP_PLUG)), .wr_addr(iss.sym), .wr_data(iss.val),
    .rd_addr(iss.sym), .rd_data(pf_d), .rd_vld(pf_v)
  );

  // Stage 1: rotor one forward.
  assign c0 = pf_v ? pf_d : s0_r.sym;

  rcu_lut #(.HAS_VLD(1'b0)) u_rotor1_fwd (
    .clk(clk), .rst_n(rst_n),
    .wr_en(s0_r.vld && (s0_r.op == OP_ROTOR1)), .wr_addr(s0_r.sym), .wr_data(s0_r.val),
    .rd_addr(c0 - s0_r.off1), .rd_data(r1_d), .rd_vld(r1_v)
  );

  // Stage 2: rotor two forward.
  rcu_lut #(.HAS_VLD(1'b0)) u_rotor2_fwd (
    .clk(clk), .rst_n(rst_n),
    .wr_en(s1_r.vld && (s1_r.op == OP_ROTOR2)), .wr_addr(s1_r.sym), .wr_data(s1_r.val),
    .rd_addr(r1_d - s1_r.off2), .rd_data(r2_d), .rd_vld(r2_v)
  );

  // Stage 3: rotor three forward.
  rcu_lut #(.HAS_VLD(1'b0)) u_rotor3_fwd (
    .clk(clk), .rst_n(rst_n),
    .wr_en(s2_r.vld && (s2_r.op == OP_ROTOR3)), .wr_addr(s2_r.sym), .wr_data(s2_r.val),
    .rd_addr(r2_d - s2_r.off3), .rd_data(r3_d), .rd_vld(r3_v)
  );

  // Stage 4: reflector.
  rcu_lut #(.HAS_VLD(1'b0)) u_reflector (
    .clk(clk), .rst_n(rst_n),
    .wr_en(s3_r.vld && (s3_r.op == OP_REFL)), .wr_addr(s3_r.sym), .wr_data(s3_r.val),
    .rd_addr(r3_d), .rd_data(rf_d), .rd_vld(rf_v)
  );

  // Stage 5: rotor three inverse; a load writes position at its value.
  rcu_lut #(.HAS_VLD(1'b1)) u_rotor3_inv (
    .clk(clk), .rst_n(rst_n),
    .wr_en(s4_r.vld && (s4_r.op == OP_ROTOR3)), .wr_addr(s4_r.val), .wr_data(s4_r.sym),
    .rd_addr(rf_d), .rd_data(i3_d), .rd_vld(i3_v)
  );

  // Stage 6: rotor two inverse. A missing entry passes zero and flags a miss.
  assign c5 = i3_v ? i3_d + s5_r.off3 : '0;

  rcu_lut #(.HAS_VLD(1'b1)) u_rotor2_inv (
    .clk(clk), .rst_n(rst_n),
    .wr_en(s5_r.vld && (s5_r.op == OP_ROTOR2)), .wr_addr(s5_r.val), .wr_data(s5_r.sym),
    .rd_addr(c5), .rd_data(i2_d), .rd_vld(i2_v)
  );

  // Stage 7: rotor one inverse.
  assign c6 = i2_v ? i2_d + s6_r.off2 : '0;

  rcu_lut #(.HAS_VLD(1'b1)) u_rotor1_inv (
    .clk(clk), .rst_n(rst_n),
    .wr_en(s6_r.vld && (s6_r.op == OP_ROTOR1)), .wr_addr(s6_r.val), .wr_data(s6_r.sym),
    .rd_addr(c6), .rd_data(i1_d), .rd_vld(i1_v)
  );

  // Stage 8: plugboard on the way out, a copy kept in step with stage 0.
  assign c7 = i1_v ? i1_d + s7_r.off1 : '0;

  rcu_lut #(.HAS_VLD(1'b1)) u_plug_out (
    .clk(clk), .rst_n(rst_n),
    .wr_en(s7_r.vld && (s7_r.op == OP_PLUG)), .wr_addr(s7_r.sym), .wr_data(s7_r.val),
    .rd_addr(c7), .rd_data(pb_d), .rd_vld(pb_v)
  );

  // Miss flags gather along the reverse path.
  always_comb begin
    s6_nxt      = s5_r;
    s6_nxt.miss = s5_r.miss | !i3_v;
    s7_nxt      = s6_r;
    s7_nxt.miss = s6_r.miss | !i2_v;
    s8_nxt      = s7_r;
    s8_nxt.miss = s7_r.miss | !i1_v;
    s8_nxt.sym  = c7;
  end

  // Pipeline registers, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
      s4_r <= '0;
      s5_r <= '0;
      s6_r <= '0;
      s7_r <= '0;
      s8_r <= '0;
    end else begin
      s0_r <= iss;
      s1_r <= s0_r;
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
      s5_r <= s4_r;
      s6_r <= s6_nxt;
      s7_r <= s7_nxt;
      s8_r <= s8_nxt;
    end
  end

  // Final plugboard pass and push of the result.
  assign res.out_symbol  = pb_v ? pb_d : s8_r.sym;
  assign res.lookup_miss = s8_r.miss;
  assign push            = s8_r.vld && (s8_r.op == OP_CIPHER);

  rcu_ofifo #(
    .DEPTH(OUT_DEPTH)
  ) u_ofifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Forward tables carry no valid flags; their flag outputs are constant.
  logic unused_vld;
  assign unused_vld = r1_v & r2_v & r3_v & rf_v;

endmodule

### hdl/rcu_checker.sv
// Port-level checks for the rotor cipher unit, bound to the top level.
// Depends on rcu_pkg and on the port names of rotor_cipher_128_unit.
module rcu_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [rcu_pkg::IN_W-1:0]  in_tdata,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [rcu_pkg::OUT_W-1:0] out_tdata
);
  import rcu_pkg::*;

  // The result queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // A plug pair transfer blocks the input for the second table write.
  a_plug_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (op_t'(in_tdata[OP_W-1:0]) == OP_PLUG) |=> !in_tready)
    else $error("input taken during plug pair write");

  // A result appearing in an empty queue comes from an earlier cipher item.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |->
      $past(in_tvalid && in_tready && (op_t'(in_tdata[OP_W-1:0]) == OP_CIPHER), 10))
    else $error("result without matching cipher item");

endmodule

bind rotor_cipher_128_unit rcu_checker u_rcu_checker (.*);

### tb/rotor_cipher_128_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotor_cipher_128_unit: drives load, begin and cipher items
// and predicts every cipher result. Depends on rcu_pkg and the unit's RTL only.
module rotor_cipher_128_unit_test;
  import rcu_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int IDLE_PCT      = 14;
  // Index past the last start register; the block ignores writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    op_t  op;
    sym_t idx;
    sym_t val;
  } item_t;

  // Tracks the cipher state and the symbols that the block still owes.
  class cipher_tracker;
    sym_t       start_off[3];
    sym_t       plug_map[ALPHABET_SIZE];
    bit         plug_set[ALPHABET_SIZE];
    sym_t       rotor_fwd[3][ALPHABET_SIZE];
    logic [7:0] rotor_inv[3][ALPHABET_SIZE];
    sym_t       reflector[ALPHABET_SIZE];
    sym_t       offset[3];
    sym_t       symbol_count;
    sym_t       middle_count;
    res_t       pending_results[$];
    int         mismatches;

    function new();
      int k, j;
      for (k = 0; k < 3; k++) begin
        start_off[k] = '0;
        offset[k]    = '0;
        for (j = 0; j < ALPHABET_SIZE; j++) begin
          rotor_fwd[k][j] = '0;
          rotor_inv[k][j] = '0;
        end
      end
      for (j = 0; j < ALPHABET_SIZE; j++) begin
        plug_map[j]  = '0;
        plug_set[j]  = 1'b0;
        reflector[j] = '0;
      end
      symbol_count = sym_t'(1);
      middle_count = sym_t'(1);
      mismatches   = 0;
    endfunction

    function void set_start(logic [CFG_IDX_W-1:0] idx, sym_t data);
      case (idx)
        CFG_ROTOR1_START: start_off[0] = data;
        CFG_ROTOR2_START: start_off[1] = data;
        CFG_ROTOR3_START: start_off[2] = data;
        default: ;
      endcase
    endfunction

    // Steps the rotors and runs one symbol through the whole machine.
    function res_t cipher_symbol(sym_t sym);
      sym_t       c;
      sym_t       pos;
      logic [7:0] entry;
      res_t       res;
      int         k;
      res.lookup_miss = 1'b0;
      c = plug_set[sym] ? plug_map[sym] : sym;

      // The middle counter at zero double-steps rotors two and three.
      symbol_count++;
      if (middle_count == '0) begin
        offset[2]++;
        offset[1]++;
        middle_count++;
      end else if (symbol_count == '0) begin
        offset[1]++;
        middle_count++;
      end
      offset[0]++;

      // Forward through the rotors and the reflector.
      for (k = 0; k < 3; k++) begin
        pos = c - offset[k];
        c   = rotor_fwd[k][pos];
      end
      c = reflector[c];

      // Back through the inverse tables; a missing entry passes zero on.
      for (k = 2; k >= 0; k--) begin
        entry = rotor_inv[k][c];
        if (!entry[7]) begin
          res.lookup_miss = 1'b1;
          c = '0;
        end else begin
          c = entry[6:0] + offset[k];
        end
      end

      if (plug_set[c]) c = plug_map[c];
      res.out_symbol = c;
      return res;
    endfunction

    // Applies one accepted input transfer to the tracked state.
    function void note_transfer(op_t op, sym_t a, sym_t b);
      int k;
      case (op)
        OP_CIPHER: pending_results = {pending_results, cipher_symbol(a)};
        OP_PLUG: begin
          plug_map[a] = b;
          plug_set[a] = 1'b1;
          plug_map[b] = a;
          plug_set[b] = 1'b1;
        end
        OP_ROTOR1, OP_ROTOR2, OP_ROTOR3: begin
          k = int'(op) - int'(OP_ROTOR1);
          rotor_fwd[k][a] = b;
          rotor_inv[k][b] = {1'b1, a};
        end
        OP_REFL: reflector[a] = b;
        OP_BEGIN: begin
          for (k = 0; k < 3; k++) offset[k] = start_off[k];
          symbol_count = sym_t'(1);
          middle_count = sym_t'(1);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Compares one result transfer with the oldest symbol owed.
    task check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with none owed", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.out_symbol !== want.out_symbol)
        report_mismatch($sformatf("out_symbol %h, predicted %h",
                                  got.out_symbol, want.out_symbol));
      if (got.lookup_miss !== want.lookup_miss)
        report_mismatch($sformatf("lookup_miss %b, predicted %b",
                                  got.lookup_miss, want.lookup_miss));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SYM_W-1:0]     cfg_data;

  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;
  bit hold_request = 1'b0;

  cipher_tracker tracker = new();

  rotor_cipher_128_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Offers one item, with random idle cycles ahead of it, until it is taken.
  task automatic send_item(op_t op, sym_t idx, sym_t val);
    @(negedge clk);
    while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      in_tdata  = IN_W'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_W - IN_FIELD_W){1'b0}}, val, idx, op};
    do @(posedge clk); while (!in_tready);
    tracker.note_transfer(op, idx, val);
  endtask

  task automatic write_start(logic [CFG_IDX_W-1:0] idx, sym_t data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_start(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure_starts(sym_t s1, sym_t s2, sym_t s3);
    write_start(CFG_ROTOR1_START, s1);
    write_start(CFG_ROTOR2_START, s2);
    write_start(CFG_ROTOR3_START, s3);
  endtask

  // Stops offering, waits for every owed result, then lets loads in flight settle.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes every entry of the three rotors and the reflector in shuffled order.
  // With fold set, rotor one only produces even values, so odd values lack an
  // inverse entry and reverse lookups can miss.
  task automatic load_tables(bit fold);
    item_t loads[$];
    item_t tmp;
    sym_t  perm[ALPHABET_SIZE];
    sym_t  t;
    int    r, k, j;
    for (r = 0; r < 3; r++) begin
      for (k = 0; k < ALPHABET_SIZE; k++) perm[k] = sym_t'(k);
      for (k = ALPHABET_SIZE - 1; k > 0; k--) begin
        j       = $urandom_range(k);
        t       = perm[k];
        perm[k] = perm[j];
        perm[j] = t;
      end
      for (k = 0; k < ALPHABET_SIZE; k++) begin
        tmp.op  = op_t'(int'(OP_ROTOR1) + r);
        tmp.idx = sym_t'(k);
        tmp.val = (fold && r == 0) ? (sym_t'(k) & 7'h7E) : perm[k];
        loads = {loads, tmp};
      end
    end
    for (k = 0; k < ALPHABET_SIZE; k++) begin
      tmp.op  = OP_REFL;
      tmp.idx = sym_t'(k);
      tmp.val = sym_t'($urandom);
      loads = {loads, tmp};
    end
    for (k = loads.size() - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      tmp      = loads[k];
      loads[k] = loads[j];
      loads[j] = tmp;
    end
    foreach (loads[k]) send_item(loads[k].op, loads[k].idx, loads[k].val);
  endtask

  // Mostly cipher symbols, mixed with table rewrites, plugs, begins and unused codes.
  // With pressure, the receiver holds off a third of the way in and the sender
  // drains everything two thirds of the way in.
  task automatic random_mix(int count, bit pressure);
    int   i, roll;
    op_t  op;
    for (i = 0; i < count; i++) begin
      if (pressure && i == count / 3) hold_request = 1'b1;
      if (pressure && i == (2 * count) / 3) wait_idle();
      roll = $urandom_range(99);
      if (roll < 66)      op = OP_CIPHER;
      else if (roll < 74) op = OP_PLUG;
      else if (roll < 82) op = op_t'(int'(OP_ROTOR1) + $urandom_range(2));
      else if (roll < 88) op = OP_REFL;
      else if (roll < 94) op = OP_BEGIN;
      else                op = OP_NONE;
      send_item(op, sym_t'($urandom), sym_t'($urandom));
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_tready = rst_n && !(rx_idle && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Every result transfer is checked at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(res_t'(out_tdata));
  end

  // Ends the run when no transfer of any kind happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // First setting, with a write to the unused index that must change nothing.
    configure_starts(7'd0, 7'd127, 7'h55);
    write_start(CFG_UNUSED, 7'h2A);
    load_tables(1'b1);

    // Directed: unused code, plug corner cases, extremes of the symbol range.
    send_item(OP_NONE, 7'd127, 7'd127);
    send_item(OP_PLUG, 7'd0, 7'd127);
    send_item(OP_PLUG, 7'd5, 7'd5);
    send_item(OP_PLUG, 7'd9, 7'd20);
    send_item(OP_PLUG, 7'd9, 7'd33);
    send_item(OP_BEGIN, 7'd0, 7'd0);
    send_item(OP_CIPHER, 7'd0, 7'd0);
    send_item(OP_CIPHER, 7'd127, 7'd127);
    send_item(OP_CIPHER, 7'd5, 7'd0);
    send_item(OP_CIPHER, 7'd9, 7'd0);
    send_item(OP_CIPHER, 7'd20, 7'd0);
    send_item(OP_CIPHER, 7'd33, 7'd0);
    send_item(OP_CIPHER, 7'h55, 7'h2A);
    send_item(OP_CIPHER, 7'h2A, 7'h55);
    send_item(OP_REFL, 7'd127, 7'd0);
    send_item(OP_REFL, 7'd0, 7'd127);
    // A rewritten rotor entry leaves the old inverse entry in place.
    send_item(OP_ROTOR2, 7'd0, 7'd127);
    send_item(OP_CIPHER, 7'd0, 7'd0);
    send_item(OP_CIPHER, 7'd127, 7'd0);
    send_item(OP_NONE, 7'd0, 7'd0);
    send_item(OP_CIPHER, 7'd64, 7'd0);
    random_mix(60, 1'b0);

    // Full permutations from here on, so every inverse entry is valid.
    wait_idle();
    configure_starts(7'd127, 7'd0, 7'd127);
    load_tables(1'b0);
    wait_idle();
    configure_starts(sym_t'($urandom), sym_t'($urandom), sym_t'($urandom));
    send_item(OP_BEGIN, sym_t'($urandom), sym_t'($urandom));
    random_mix(100, 1'b1);

    // A stretch with no idling on either side.
    wait_idle();
    configure_starts(7'd127, 7'd127, 7'd127);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_item(OP_BEGIN, 7'd0, 7'd0);
    random_mix(80, 1'b0);
    wait_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    configure_starts(7'd0, 7'd0, 7'd0);
    send_item(OP_BEGIN, 7'd127, 7'd127);
    random_mix(40, 1'b0);

    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### sim.f
hdl/rcu_pkg.sv
hdl/rcu_lut.sv
hdl/rcu_front.sv
hdl/rcu_ofifo.sv
hdl/rotor_cipher_128_unit.sv
hdl/rcu_checker.sv
tb/rotor_cipher_128_unit_test.sv
